FILE: sv/snfr_pkg.sv
// Shared types, constants and codes of the serial node frame receiver.
package snfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 64;

  localparam logic [7:0] BYTE_ATTN      = 8'hFF;
  localparam logic [7:0] BYTE_STX       = 8'h02;
  localparam logic [7:0] BYTE_ETX       = 8'h03;
  localparam logic [7:0] BYTE_DLE       = 8'h10;
  localparam logic [7:0] ADDR_BROADCAST = 8'h00;
  localparam logic [7:0] ADDR_RESET     = 8'd65;
  localparam logic [7:0] DEST_IDLE      = 8'hFF;
  localparam logic [7:0] TYPE_IDLE      = 8'h00;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ATTN2 = 3'd1,
    PH_STX   = 3'd2,
    PH_DEST  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_BODY  = 3'd5,
    PH_ESC   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_OURS     = 3'd2,
    EV_OTHER    = 3'd3,
    EV_OVERFLOW = 3'd4
  } event_e;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  payload_byte;
    logic [5:0]  payload_index;
    logic [7:0]  frame_dest;
    logic [7:0]  frame_type;
    logic [6:0]  frame_length;
    logic [31:0] chars_total;
    logic [31:0] frames_seen;
    logic [31:0] frames_accepted;
  } res_t;

endpackage

FILE: sv/snfr_if.sv
// Valid/ready channel interfaces for received bytes and receiver results.
interface snfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface snfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  payload_byte;
  logic [5:0]  payload_index;
  logic [7:0]  frame_dest;
  logic [7:0]  frame_type;
  logic [6:0]  frame_length;
  logic [31:0] chars_total;
  logic [31:0] frames_seen;
  logic [31:0] frames_accepted;

  modport source (
    output valid, output event_res, output payload_byte, output payload_index,
    output frame_dest, output frame_type, output frame_length,
    output chars_total, output frames_seen, output frames_accepted,
    input ready
  );
  modport sink (
    input valid, input event_res, input payload_byte, input payload_index,
    input frame_dest, input frame_type, input frame_length,
    input chars_total, input frames_seen, input frames_accepted,
    output ready
  );
endinterface

FILE: sv/serial_node_frame_receiver_core.sv
// Top level of the serial node frame receiver.
// Usage:
//   byte_in_i carries one received serial byte per request (valid/ready).
//   res_o carries exactly one result per byte: event code, stored payload
//   byte and index, current destination/type/length and three counters.
//   cfg_we_i/cfg_wdata_i write the node address; write it only while idle.
// Timing:
//   A byte accepted into the input register is decoded, once the
//   two-entry result buffer has room, into that buffer, and its result
//   is presented from the buffer. One byte per cycle is sustained while
//   res_o.ready stays high; the frame state update is one small
//   compare-and-count step between the input register and the buffer.
// Reset:
//   rst_ni clears the phase to start, destination to 0xFF, type, fill and
//   counters to zero, and the node address to 65. No clearing pass.
// Stall:
//   When the result sink holds ready low, the buffer fills; the input
//   register then holds and byte_in_i.ready drops until a result drains.
module serial_node_frame_receiver_core #(
  parameter int unsigned MaxPayload = snfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  snfr_byte_if.sink         byte_in_i,
  snfr_res_if.source        res_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  logic           room;
  logic           push;
  snfr_pkg::res_t push_data;
  snfr_pkg::res_t out_data;

  snfr_deframer #(
    .MaxPayload (MaxPayload)
  ) u_deframer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_in_i.valid),
    .in_ready_o  (byte_in_i.ready),
    .in_byte_i   (byte_in_i.byte_in),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .room_i      (room),
    .push_o      (push),
    .res_o       (push_data)
  );

  snfr_res_buf u_res_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .room_o      (room),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .out_data_o  (out_data)
  );

  assign res_o.event_res       = out_data.event_res;
  assign res_o.payload_byte    = out_data.payload_byte;
  assign res_o.payload_index   = out_data.payload_index;
  assign res_o.frame_dest      = out_data.frame_dest;
  assign res_o.frame_type      = out_data.frame_type;
  assign res_o.frame_length    = out_data.frame_length;
  assign res_o.chars_total     = out_data.chars_total;
  assign res_o.frames_seen     = out_data.frames_seen;
  assign res_o.frames_accepted = out_data.frames_accepted;

endmodule

FILE: sv/snfr_deframer.sv
// Input byte register, frame state machine, counters and result formation.
module snfr_deframer #(
  parameter int unsigned MaxPayload = snfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              room_i,
  output logic              push_o,
  output snfr_pkg::res_t    res_o
);

  localparam int unsigned FillW = $clog2(MaxPayload + 1);
  localparam logic [FillW-1:0] FillMax = FillW'(MaxPayload);

  logic                 valid_q;
  logic [7:0]           byte_q;
  logic [7:0]           node_addr_q;
  snfr_pkg::phase_e     phase_q, phase_d;
  logic [7:0]           dest_q, dest_d;
  logic [7:0]           type_q, type_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [31:0]          chars_q, chars_d;
  logic [31:0]          seen_q, seen_d;
  logic [31:0]          accepted_q, accepted_d;
  snfr_pkg::event_e     ev;
  logic [7:0]           pb;
  logic [FillW-1:0]     pi;
  logic                 advance;
  logic [FillW+6:0]     len_ext;
  logic [FillW+5:0]     idx_ext;

  assign advance    = valid_q && room_i;
  assign in_ready_o = !valid_q || room_i;
  assign push_o     = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= snfr_pkg::ADDR_RESET;
    end else if (cfg_we_i) begin
      node_addr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= snfr_pkg::PH_START;
      dest_q     <= snfr_pkg::DEST_IDLE;
      type_q     <= snfr_pkg::TYPE_IDLE;
      fill_q     <= '0;
      chars_q    <= '0;
      seen_q     <= '0;
      accepted_q <= '0;
    end else begin
      phase_q    <= phase_d;
      dest_q     <= dest_d;
      type_q     <= type_d;
      fill_q     <= fill_d;
      chars_q    <= chars_d;
      seen_q     <= seen_d;
      accepted_q <= accepted_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    dest_d     = dest_q;
    type_d     = type_q;
    fill_d     = fill_q;
    chars_d    = chars_q;
    seen_d     = seen_q;
    accepted_d = accepted_q;
    ev         = snfr_pkg::EV_NONE;
    pb         = 8'h00;
    pi         = '0;
    if (advance) begin
      chars_d = chars_q + 32'd1;
      unique case (phase_q)
        snfr_pkg::PH_ATTN2: begin
          phase_d = (byte_q == snfr_pkg::BYTE_ATTN) ? snfr_pkg::PH_STX : snfr_pkg::PH_START;
        end
        snfr_pkg::PH_STX: begin
          phase_d = (byte_q == snfr_pkg::BYTE_STX) ? snfr_pkg::PH_DEST : snfr_pkg::PH_START;
        end
        snfr_pkg::PH_DEST: begin
          dest_d  = byte_q;
          phase_d = snfr_pkg::PH_TYPE;
        end
        snfr_pkg::PH_TYPE: begin
          type_d  = byte_q;
          phase_d = snfr_pkg::PH_BODY;
        end
        snfr_pkg::PH_BODY, snfr_pkg::PH_ESC: begin
          if (phase_q == snfr_pkg::PH_BODY && byte_q == snfr_pkg::BYTE_ETX) begin
            seen_d  = seen_q + 32'd1;
            phase_d = snfr_pkg::PH_START;
            if (dest_q == snfr_pkg::ADDR_BROADCAST || dest_q == node_addr_q) begin
              accepted_d = accepted_q + 32'd1;
              ev         = snfr_pkg::EV_OURS;
            end else begin
              ev = snfr_pkg::EV_OTHER;
            end
          end else if (phase_q == snfr_pkg::PH_BODY && byte_q == snfr_pkg::BYTE_DLE) begin
            phase_d = snfr_pkg::PH_ESC;
          end else if (fill_q >= FillMax) begin
            ev      = snfr_pkg::EV_OVERFLOW;
            phase_d = snfr_pkg::PH_START;
          end else begin
            ev      = snfr_pkg::EV_STORED;
            pb      = byte_q;
            pi      = fill_q;
            fill_d  = fill_q + FillW'(1);
            phase_d = snfr_pkg::PH_BODY;
          end
        end
        default: begin
          phase_d = (byte_q == snfr_pkg::BYTE_ATTN) ? snfr_pkg::PH_ATTN2 : snfr_pkg::PH_START;
          dest_d  = snfr_pkg::DEST_IDLE;
          type_d  = snfr_pkg::TYPE_IDLE;
          fill_d  = '0;
        end
      endcase
    end
  end

  assign len_ext = {7'b0, fill_d};
  assign idx_ext = {6'b0, pi};

  always_comb begin
    res_o.event_res       = ev;
    res_o.payload_byte    = pb;
    res_o.payload_index   = idx_ext[5:0];
    res_o.frame_dest      = dest_d;
    res_o.frame_type      = type_d;
    res_o.frame_length    = len_ext[6:0];
    res_o.chars_total     = chars_d;
    res_o.frames_seen     = seen_d;
    res_o.frames_accepted = accepted_d;
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("payload fill count beyond limit");

  a_esc_from_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == snfr_pkg::PH_ESC) |->
      ($past(phase_q) == snfr_pkg::PH_BODY || $past(phase_q) == snfr_pkg::PH_ESC))
    else $error("escape phase entered from outside the body");

  a_accept_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && ev == snfr_pkg::EV_OURS) |=> (accepted_q == $past(accepted_q) + 32'd1))
    else $error("accepted counter missed a frame");

  a_seen_only_etx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!advance) |=> (seen_q == $past(seen_q) && chars_q == $past(chars_q)))
    else $error("counters moved without a byte");
`endif

endmodule

FILE: sv/snfr_res_buf.sv
// Two-entry result buffer between the deframer and the result channel.
module snfr_res_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  snfr_pkg::res_t push_data_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output snfr_pkg::res_t out_data_o
);

  snfr_pkg::res_t mem_q [2];
  logic [1:0]     count_q;
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic           pop;

  assign out_valid_o = (count_q != 2'd0);
  assign room_o      = (count_q != 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != 2'd2))
    else $error("request pushed into full result buffer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("result buffer pointers disagree with count");
`endif

endmodule

FILE: tb/serial_node_frame_receiver_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial node frame receiver core with random deframing traffic.
module serial_node_frame_receiver_core_tb;

  localparam int unsigned MaxPayload = snfr_pkg::MAX_PAYLOAD_DEF;
  localparam int WatchLimit = 2000;
  localparam int ItemTarget = 900;
  localparam int HoldCycles = 300;
  localparam int NumPhases = 6;

  class deframer_scoreboard;
    logic [7:0]       node_addr;
    snfr_pkg::phase_e ph;
    logic [7:0]       dest_q;
    logic [7:0]       type_q;
    int unsigned      fill;
    logic [31:0]      n_chars;
    logic [31:0]      n_seen;
    logic [31:0]      n_accepted;
    snfr_pkg::res_t   expected_results[$];
    int               errors;

    function new();
      node_addr  = snfr_pkg::ADDR_RESET;
      ph         = snfr_pkg::PH_START;
      dest_q     = snfr_pkg::DEST_IDLE;
      type_q     = snfr_pkg::TYPE_IDLE;
      fill       = 0;
      n_chars    = '0;
      n_seen     = '0;
      n_accepted = '0;
      errors     = 0;
    endfunction

    function void set_address(logic [7:0] a);
      node_addr = a;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    function void store_payload(logic [7:0] b, inout snfr_pkg::res_t r);
      if (fill >= MaxPayload) begin
        ph = snfr_pkg::PH_START;
        r.event_res = snfr_pkg::EV_OVERFLOW;
      end else begin
        r.event_res = snfr_pkg::EV_STORED;
        r.payload_byte = b;
        r.payload_index = fill[5:0];
        fill++;
        ph = snfr_pkg::PH_BODY;
      end
    endfunction

    function void note_byte(logic [7:0] b);
      snfr_pkg::res_t r;
      r = '0;
      r.event_res = snfr_pkg::EV_NONE;
      n_chars++;
      case (ph)
        snfr_pkg::PH_ATTN2:
          ph = (b == snfr_pkg::BYTE_ATTN) ? snfr_pkg::PH_STX : snfr_pkg::PH_START;
        snfr_pkg::PH_STX:
          ph = (b == snfr_pkg::BYTE_STX) ? snfr_pkg::PH_DEST : snfr_pkg::PH_START;
        snfr_pkg::PH_DEST: begin
          dest_q = b;
          ph = snfr_pkg::PH_TYPE;
        end
        snfr_pkg::PH_TYPE: begin
          type_q = b;
          ph = snfr_pkg::PH_BODY;
        end
        snfr_pkg::PH_BODY: begin
          if (b == snfr_pkg::BYTE_ETX) begin
            n_seen++;
            if (dest_q == snfr_pkg::ADDR_BROADCAST || dest_q == node_addr) begin
              n_accepted++;
              r.event_res = snfr_pkg::EV_OURS;
            end else begin
              r.event_res = snfr_pkg::EV_OTHER;
            end
            ph = snfr_pkg::PH_START;
          end else if (b == snfr_pkg::BYTE_DLE) begin
            ph = snfr_pkg::PH_ESC;
          end else begin
            store_payload(b, r);
          end
        end
        snfr_pkg::PH_ESC: store_payload(b, r);
        default: begin
          ph = (b == snfr_pkg::BYTE_ATTN) ? snfr_pkg::PH_ATTN2 : snfr_pkg::PH_START;
          dest_q = snfr_pkg::DEST_IDLE;
          type_q = snfr_pkg::TYPE_IDLE;
          fill = 0;
        end
      endcase
      r.frame_dest = dest_q;
      r.frame_type = type_q;
      r.frame_length = fill[6:0];
      r.chars_total = n_chars;
      r.frames_seen = n_seen;
      r.frames_accepted = n_accepted;
      expected_results.push_back(r);
    endfunction

    task check_result(snfr_pkg::res_t got);
      snfr_pkg::res_t want;
      if (expected_results.size() == 0) begin
        report("result without request", got.chars_total, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.event_res !== want.event_res)
          report("event_res", 32'(got.event_res), 32'(want.event_res));
        if (got.payload_byte !== want.payload_byte)
          report("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
        if (got.payload_index !== want.payload_index)
          report("payload_index", 32'(got.payload_index), 32'(want.payload_index));
        if (got.frame_dest !== want.frame_dest)
          report("frame_dest", 32'(got.frame_dest), 32'(want.frame_dest));
        if (got.frame_type !== want.frame_type)
          report("frame_type", 32'(got.frame_type), 32'(want.frame_type));
        if (got.frame_length !== want.frame_length)
          report("frame_length", 32'(got.frame_length), 32'(want.frame_length));
        if (got.chars_total !== want.chars_total)
          report("chars_total", got.chars_total, want.chars_total);
        if (got.frames_seen !== want.frames_seen)
          report("frames_seen", got.frames_seen, want.frames_seen);
        if (got.frames_accepted !== want.frames_accepted)
          report("frames_accepted", got.frames_accepted, want.frames_accepted);
      end
    endtask

    function int pending();
      return expected_results.size();
    endfunction

    task close();
      if (expected_results.size() != 0)
        report("results missing", 32'(expected_results.size()), '0);
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  snfr_byte_if bif ();
  snfr_res_if  rif ();

  deframer_scoreboard sb = new();

  logic [7:0] byte_stream[$];
  int         sent = 0;
  int         results_seen = 0;
  int         quiet = 0;
  int         tx_left = 0;
  int         rx_left = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  serial_node_frame_receiver_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_in_i  (bif),
    .res_o      (rif),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic int draw_gap(inout int left, inout bit calm);
    if (left <= 0) begin
      calm = ($urandom_range(0, 3) == 0);
      left = $urandom_range(10, 60);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 7))
      0: return snfr_pkg::BYTE_ETX;
      1: return snfr_pkg::BYTE_DLE;
      2: return snfr_pkg::BYTE_ATTN;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void push(logic [7:0] b);
    byte_stream.push_back(b);
  endfunction

  function automatic void push_header(logic [7:0] dest, logic [7:0] typ);
    push(snfr_pkg::BYTE_ATTN);
    push(snfr_pkg::BYTE_ATTN);
    push(snfr_pkg::BYTE_STX);
    push(dest);
    push(typ);
  endfunction

  function automatic void push_frame(logic [7:0] dest, logic [7:0] typ, int len);
    logic [7:0] pb;
    push_header(dest, typ);
    for (int i = 0; i < len; i++) begin
      pb = pick_payload();
      if (pb == snfr_pkg::BYTE_ETX || pb == snfr_pkg::BYTE_DLE || $urandom_range(0, 9) == 0)
        push(snfr_pkg::BYTE_DLE);
      push(pb);
    end
    push(snfr_pkg::BYTE_ETX);
  endfunction

  function automatic void push_random_sequence();
    int         kind;
    int         sel;
    int         len;
    logic [7:0] dest;
    kind = $urandom_range(0, 19);
    if (kind < 15) begin
      case ($urandom_range(0, 3))
        0: dest = sb.node_addr;
        1: dest = snfr_pkg::ADDR_BROADCAST;
        2: dest = 8'($urandom);
        default: dest = sb.node_addr ^ 8'h01;
      endcase
      sel = $urandom_range(0, 19);
      if (sel < 14) len = $urandom_range(0, 8);
      else if (sel < 16) len = MaxPayload;
      else if (sel < 18) len = MaxPayload + $urandom_range(1, 3);
      else len = $urandom_range(9, 40);
      push_frame(dest, 8'($urandom), len);
    end else if (kind < 17) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) push(8'($urandom));
    end else if (kind == 17) begin
      push(snfr_pkg::BYTE_ATTN);
      push(8'($urandom));
    end else if (kind == 18) begin
      push(snfr_pkg::BYTE_ATTN);
      push(snfr_pkg::BYTE_ATTN);
      push(8'($urandom));
    end else begin
      push_header(8'($urandom), 8'($urandom));
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) push(8'($urandom));
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_gap(tx_left, tx_calm);
    repeat (gap) begin
      @(negedge clk_i);
      bif.valid <= 1'b0;
    end
    @(negedge clk_i);
    bif.valid   <= 1'b1;
    bif.byte_in <= b;
    @(posedge clk_i);
    while (!bif.ready) @(posedge clk_i);
    sb.note_byte(b);
    sent++;
  endtask

  task automatic flush_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
  endtask

  task automatic run_random(int goal);
    while (sent < goal) begin
      push_random_sequence();
      flush_stream();
    end
  endtask

  task automatic drain_requests(int settle);
    @(negedge clk_i);
    bif.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_address(logic [7:0] a);
    drain_requests(4);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_address(a);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (bif.valid && bif.ready) || (rif.valid && rif.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int             gap;
    snfr_pkg::res_t got;
    rif.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap(rx_left, rx_calm);
      if (results_seen == 250 || results_seen == 650) gap = HoldCycles;
      repeat (gap) begin
        @(negedge clk_i);
        rif.ready <= 1'b0;
      end
      @(negedge clk_i);
      rif.ready <= 1'b1;
      @(posedge clk_i);
      while (!rif.valid) @(posedge clk_i);
      got.event_res       = snfr_pkg::event_e'(rif.event_res);
      got.payload_byte    = rif.payload_byte;
      got.payload_index   = rif.payload_index;
      got.frame_dest      = rif.frame_dest;
      got.frame_type      = rif.frame_type;
      got.frame_length    = rif.frame_length;
      got.chars_total     = rif.chars_total;
      got.frames_seen     = rif.frames_seen;
      got.frames_accepted = rif.frames_accepted;
      results_seen++;
      sb.check_result(got);
    end
  end

  initial begin
    logic [7:0] addrs[NumPhases - 1];
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 8'h00;
    bif.valid   = 1'b0;
    bif.byte_in = 8'h00;
    addrs = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), snfr_pkg::ADDR_RESET};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push(8'hAA);
    push(snfr_pkg::BYTE_ATTN);
    push(8'h00);
    push(snfr_pkg::BYTE_ATTN);
    push(snfr_pkg::BYTE_ATTN);
    push(8'h55);
    push_header(snfr_pkg::ADDR_RESET, 8'h00);
    push(8'h00);
    push(8'hFF);
    push(snfr_pkg::BYTE_DLE);
    push(snfr_pkg::BYTE_ETX);
    push(snfr_pkg::BYTE_DLE);
    push(snfr_pkg::BYTE_DLE);
    push(snfr_pkg::BYTE_ETX);
    push_header(snfr_pkg::ADDR_BROADCAST, 8'hFF);
    push(snfr_pkg::BYTE_ETX);
    push_header(8'h42, 8'h7E);
    push(snfr_pkg::BYTE_ETX);
    flush_stream();
    run_random(ItemTarget / NumPhases);

    for (int p = 0; p < NumPhases - 1; p++) begin
      write_address(addrs[p]);
      run_random(ItemTarget * (p + 2) / NumPhases);
    end

    drain_requests(0);
    repeat (8) @(posedge clk_i);
    sb.close();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
